### design/zgp_pkg.sv
`default_nettype none
package zgp_pkg;

  localparam int WIDTH     = 40;
  localparam int HEIGHT    = 26;
  localparam int CELLS     = WIDTH * HEIGHT;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(WIDTH);
  // signed width for y*WIDTH+x+count over the whole parameter range
  localparam int CALC_W    = 16;
  localparam int ATTR_COLS = 3;

  localparam logic [7:0] FAR_DEPTH   = 8'hFF;
  localparam logic [7:0] SPACE_GLYPH = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_SPAN  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic signed [7:0]  count;
    logic [7:0]         depth;
    logic [7:0]         glyph;
    logic [10:0]        read_address;
  } zgp_in_t;

  typedef struct packed {
    logic [7:0] cell_glyph;
    logic [7:0] cell_depth;
    logic [6:0] cells_written;
  } zgp_out_t;

  typedef struct packed {
    logic load;
    logic read_issue;
    logic clr_init;
    logic clr_step;
    logic setup;
    logic test_rd;
    logic skip;
    logic cmp_wr;
    logic finish;
  } zgp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic k_zero;
    logic addr_ok;
    logic clr_last;
    logic out_busy;
  } zgp_status_t;

endpackage
`default_nettype wire

### design/zgp_ram.sv
`default_nettype none
module zgp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/zgp_ctrl.sv
`default_nettype none
module zgp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire zgp_pkg::zgp_status_t status_i,
  output zgp_pkg::zgp_cmd_t        cmd_o
);
  import zgp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_TEST   = 7'b0001000,
    ST_CMPWR  = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        unique case (status_i.op)
          OP_CLEAR: begin
            cmd_o.clr_init = 1'b1;
            state_d        = ST_CLEAR;
          end
          OP_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d          = ST_RDWAIT;
          end
          default: begin
            cmd_o.setup = 1'b1;
            state_d     = ST_TEST;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_TEST: begin
        priority if (status_i.k_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.addr_ok) begin
          cmd_o.test_rd = 1'b1;
          state_d       = ST_CMPWR;
        end else begin
          // cell outside the store: drop it
          cmd_o.skip = 1'b1;
        end
      end
      ST_CMPWR: begin
        cmd_o.cmp_wr = 1'b1;
        state_d      = ST_TEST;
      end
      ST_RDWAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### design/zgp_dp.sv
`default_nettype none
module zgp_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire zgp_pkg::zgp_in_t    in_item_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire zgp_pkg::zgp_cmd_t   cmd_i,
  output zgp_pkg::zgp_status_t     status_o,
  output logic                     out_valid_o,
  output zgp_pkg::zgp_out_t        out_item_o,
  input  wire logic                out_stall_i
);
  import zgp_pkg::*;

  localparam logic signed [CALC_W-1:0] WIDTH_S = CALC_W'(WIDTH);
  localparam logic signed [CALC_W-1:0] CELLS_S = CALC_W'(CELLS);

  zgp_in_t                  in_q;
  logic                     rd_in_range_q;
  logic                     color_q;
  logic signed [CALC_W-1:0] addr_q, addr_d;
  logic [6:0]               k_q, k_d;
  logic [6:0]               cnt_q;
  logic [COL_W-1:0]         col_q;
  logic                     out_valid_q;
  zgp_out_t                 out_q;

  logic signed [CALC_W-1:0] base;
  logic                     plot_ok;
  logic                     hit;
  logic                     depth_we, glyph_we, ram_re;
  logic [7:0]               depth_wdata, glyph_wdata;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [7:0]               depth_rdata, glyph_rdata;

  // plot window; row 0 and column 0 (or the attribute columns) are never plotted
  always_comb begin
    base    = CALC_W'(in_q.y) * WIDTH_S + CALC_W'(in_q.x);
    plot_ok = (in_q.y > 0) && (in_q.y < HEIGHT) && (in_q.x < WIDTH) &&
              (color_q ? (in_q.x > (ATTR_COLS - 1)) : (in_q.x > 0));
    if (in_q.op == OP_SPAN) begin
      addr_d = base + CALC_W'(in_q.count);
      k_d    = (in_q.count > 0) ? in_q.count[6:0] : 7'd0;
    end else begin
      addr_d = base;
      k_d    = plot_ok ? 7'd1 : 7'd0;
    end
  end

  assign hit = cmd_i.cmp_wr && (in_q.depth < depth_rdata);

  assign ram_waddr   = addr_q[ADDR_W-1:0];
  assign ram_raddr   = cmd_i.read_issue ? ADDR_W'(in_q.read_address) : addr_q[ADDR_W-1:0];
  assign ram_re      = cmd_i.read_issue | cmd_i.test_rd;
  assign depth_we    = cmd_i.clr_step | hit;
  assign glyph_we    = (cmd_i.clr_step && (!color_q || col_q >= COL_W'(ATTR_COLS))) | hit;
  assign depth_wdata = cmd_i.clr_step ? FAR_DEPTH : in_q.depth;
  assign glyph_wdata = cmd_i.clr_step ? SPACE_GLYPH : in_q.glyph;

  zgp_ram #(.DATA_W(8), .DEPTH(CELLS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (ram_waddr),
    .wdata_i (depth_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (depth_rdata)
  );

  zgp_ram #(.DATA_W(8), .DEPTH(CELLS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (ram_waddr),
    .wdata_i (glyph_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (glyph_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q          <= in_item_i;
      rd_in_range_q <= (32'(in_item_i.read_address) < CELLS);
      cnt_q         <= 7'd0;
    end
    if (cmd_i.setup) begin
      addr_q <= addr_d;
      k_q    <= k_d;
    end
    if (cmd_i.clr_init) begin
      addr_q <= '0;
      col_q  <= '0;
    end
    if (cmd_i.clr_step) begin
      addr_q <= addr_q + CALC_W'(1);
      col_q  <= (col_q == COL_W'(WIDTH - 1)) ? '0 : col_q + COL_W'(1);
    end
    // spans walk from the far end back toward the start
    if (cmd_i.skip || cmd_i.cmp_wr) begin
      addr_q <= addr_q - CALC_W'(1);
      k_q    <= k_q - 7'd1;
    end
    if (hit) begin
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.finish) begin
      if (in_q.op == OP_READ && rd_in_range_q) begin
        out_q.cell_glyph <= glyph_rdata;
        out_q.cell_depth <= depth_rdata;
      end else begin
        out_q.cell_glyph <= 8'd0;
        out_q.cell_depth <= 8'd0;
      end
      out_q.cells_written <= cnt_q;
    end
  end

  assign status_o.op       = in_q.op;
  assign status_o.k_zero   = (k_q == 7'd0);
  assign status_o.addr_ok  = (addr_q >= 0) && (addr_q < CELLS_S);
  assign status_o.clr_last = (addr_q == CALC_W'(CELLS - 1));
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

### design/zbuffer_glyph_plotter_core.sv
`default_nettype none
// Depth-tested character-cell plotter over a glyph store and a depth store of
// WIDTH x HEIGHT cells, each held in a single-port-write, registered-read RAM.
// One item is worked on at a time and each gives one result. A clear writes
// every depth cell once, one per cycle, and every glyph cell but those of the
// attribute columns in color mode. After setup, a plot or span does a
// read-modify-write (a read, then a compare and write) for each cell inside
// the store and skips each cell outside it; a read waits on the registered
// RAM read. The next item is taken as soon as the result is in the output
// register, even while it is still stalled. The stores hold garbage until
// the first clear; color_mode must only be changed while no item is in
// flight.
module zbuffer_glyph_plotter_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire zgp_pkg::zgp_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output zgp_pkg::zgp_out_t      out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i
);
  import zgp_pkg::*;

  zgp_cmd_t    cmd;
  zgp_status_t status;

  zgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  zgp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

### design/zgp_checker.sv
`default_nettype none
module zgp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire zgp_pkg::zgp_out_t out_item_o
);
  import zgp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in flight");

  // read results carry no write count
  a_read_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.cell_glyph != 8'd0 || out_item_o.cell_depth != 8'd0)
      |-> out_item_o.cells_written == 7'd0)
    else $error("read result with nonzero write count");

endmodule

bind zbuffer_glyph_plotter_core zgp_checker u_zgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

### test/zbuffer_glyph_plotter_core_tb.sv
`timescale 1ns / 1ps

module zbuffer_glyph_plotter_core_tb;
  import zgp_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 213;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  zgp_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  zgp_out_t out_item_o;
  logic     cfg_we_i = 1'b0;
  logic     cfg_wdata_i = 1'b0;

  zbuffer_glyph_plotter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block's stores and its color-mode register
  logic [7:0] depth_mem [CELLS];
  logic [7:0] glyph_mem [CELLS];
  bit         color_mode_q = 1'b0;

  zgp_in_t  pending_items [$];
  zgp_out_t expected_cells [$];
  int       recent_cells [$];
  int       items_sent = 0;
  int       results_checked = 0;
  int       mismatches = 0;
  int       hold_left = 0;
  int       holds_done = 0;
  int       cycle_count = 0;
  zgp_out_t oldest_cell;

  function automatic bit depth_test_write(int addr, logic [7:0] dep, logic [7:0] gly);
    if (addr < 0 || addr >= CELLS) return 1'b0;
    if (dep < depth_mem[addr]) begin
      depth_mem[addr] = dep;
      glyph_mem[addr] = gly;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic zgp_out_t apply_draw_op(zgp_in_t it);
    zgp_out_t res;
    int xs, ys, cnt, lo_col, written;
    res = '0;
    xs = $signed(it.x);
    ys = $signed(it.y);
    cnt = $signed(it.count);
    written = 0;
    case (it.op)
      OP_CLEAR: begin
        for (int a = 0; a < CELLS; a++) begin
          depth_mem[a] = FAR_DEPTH;
          // attribute columns keep their glyphs in color mode
          if (!color_mode_q || (a % WIDTH) >= ATTR_COLS) glyph_mem[a] = SPACE_GLYPH;
        end
      end
      OP_PLOT: begin
        lo_col = color_mode_q ? ATTR_COLS - 1 : 0;
        if (ys > 0 && ys < HEIGHT && xs > lo_col && xs < WIDTH)
          written = depth_test_write(ys * WIDTH + xs, it.depth, it.glyph);
      end
      OP_SPAN: begin
        // no row clipping, only the store bounds drop cells
        for (int k = cnt; k > 0; k--)
          written += depth_test_write(ys * WIDTH + xs + k, it.depth, it.glyph);
      end
      default: begin
        if (it.read_address < CELLS) begin
          res.cell_glyph = glyph_mem[it.read_address];
          res.cell_depth = depth_mem[it.read_address];
        end
      end
    endcase
    res.cells_written = written[6:0];
    return res;
  endfunction

  function automatic zgp_in_t make_item(op_e op, int x, int y, int count, int depth,
                                        int glyph, int raddr);
    zgp_in_t it;
    it.op = op;
    it.x = x[7:0];
    it.y = y[7:0];
    it.count = count[7:0];
    it.depth = depth[7:0];
    it.glyph = glyph[7:0];
    it.read_address = raddr[10:0];
    return it;
  endfunction

  function automatic void remember_cell(int addr);
    if (addr >= 0 && addr < CELLS) begin
      recent_cells.push_back(addr);
      if (recent_cells.size() > 32) recent_cells.delete(0);
    end
  endfunction

  function automatic zgp_in_t random_item();
    int pick, x, y, count, raddr;
    op_e op;
    pick = $urandom_range(99);
    x = int'($urandom_range(255)) - 128;
    y = int'($urandom_range(255)) - 128;
    count = int'($urandom_range(255)) - 128;
    raddr = $urandom_range(2047);
    if (pick < 3) begin
      op = OP_CLEAR;
    end else if (pick < 40) begin
      op = OP_PLOT;
      // mostly on or just past the visible edges
      if ($urandom_range(99) < 85) begin
        x = $urandom_range(WIDTH);
        y = $urandom_range(HEIGHT);
      end
      if (y > 0 && y < HEIGHT && x >= 0 && x < WIDTH) remember_cell(y * WIDTH + x);
    end else if (pick < 65) begin
      op = OP_SPAN;
      if ($urandom_range(99) < 90) begin
        y = int'($urandom_range(HEIGHT + 1)) - 1;
        x = int'($urandom_range(WIDTH + 10)) - 10;
        count = ($urandom_range(9) == 0) ? int'($urandom_range(127))
                                         : int'($urandom_range(40)) - 3;
      end
      if (count > 0) remember_cell(y * WIDTH + x + 1);
    end else begin
      op = OP_READ;
      if (recent_cells.size() != 0 && $urandom_range(99) < 60)
        raddr = recent_cells[$urandom_range(recent_cells.size() - 1)];
      else if ($urandom_range(99) < 70)
        raddr = $urandom_range(CELLS - 1);
    end
    return make_item(op, x, y, count, $urandom_range(255), $urandom_range(255), raddr);
  endfunction

  // sender: one item offered at a time, held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_cells.push_back(apply_draw_op(in_item_i));
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 &&
            ((items_sent >= 300 && items_sent < 450) || $urandom_range(99) >= 16)) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_checked >= (holds_done == 0 ? 150 : 500)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // receiver: checks each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      results_checked <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result %h with none expected", $time, out_item_o);
          mismatches++;
        end else begin
          oldest_cell = expected_cells.pop_front();
          if (out_item_o.cell_glyph !== oldest_cell.cell_glyph) begin
            $display("%0t: cell_glyph expected %h got %h", $time,
                     oldest_cell.cell_glyph, out_item_o.cell_glyph);
            mismatches++;
          end
          if (out_item_o.cell_depth !== oldest_cell.cell_depth) begin
            $display("%0t: cell_depth expected %h got %h", $time,
                     oldest_cell.cell_depth, out_item_o.cell_depth);
            mismatches++;
          end
          if (out_item_o.cells_written !== oldest_cell.cells_written) begin
            $display("%0t: cells_written expected %0d got %0d", $time,
                     oldest_cell.cells_written, out_item_o.cells_written);
            mismatches++;
          end
        end
        results_checked <= results_checked + 1;
      end
      out_stall_i <= (hold_left != 0) ||
                     (!(results_checked >= 300 && results_checked < 450) &&
                      $urandom_range(99) < 16);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_cells.size() != 0);
    // margin for the block to settle after its last result
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_color_mode(bit mode);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    color_mode_q = mode;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_color_mode(1'b0);
    // first item must be a clear, the stores are garbage until then
    pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_PLOT, 1, 1, 0, 10, 8'h41, 0));
    pending_items.push_back(make_item(OP_PLOT, WIDTH - 1, HEIGHT - 1, 0, 0, 8'hFF, 0));
    pending_items.push_back(make_item(OP_PLOT, 0, 5, 0, 1, 8'h43, 0));
    pending_items.push_back(make_item(OP_PLOT, WIDTH, 5, 0, 1, 8'h43, 0));
    pending_items.push_back(make_item(OP_PLOT, 5, 0, 0, 1, 8'h43, 0));
    pending_items.push_back(make_item(OP_PLOT, 5, HEIGHT, 0, 1, 8'h43, 0));
    pending_items.push_back(make_item(OP_PLOT, -128, -128, -128, 1, 8'h80, 0));
    pending_items.push_back(make_item(OP_PLOT, 127, 127, 127, 1, 8'h7F, 2047));
    pending_items.push_back(make_item(OP_PLOT, 1, 1, 0, 10, 8'h44, 0));
    pending_items.push_back(make_item(OP_PLOT, 1, 1, 0, 9, 8'h42, 0));
    pending_items.push_back(make_item(OP_PLOT, 2, 2, 0, 255, 8'h45, 0));
    pending_items.push_back(make_item(OP_SPAN, 35, 2, 10, 50, 8'h46, 0));
    pending_items.push_back(make_item(OP_SPAN, 3, 3, 0, 0, 8'h47, 0));
    pending_items.push_back(make_item(OP_SPAN, 3, 3, -128, 0, 8'h47, 0));
    pending_items.push_back(make_item(OP_SPAN, 0, -1, 127, 60, 8'h48, 0));
    pending_items.push_back(make_item(OP_SPAN, 30, HEIGHT - 1, 20, 40, 8'h49, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, WIDTH + 1));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, CELLS - 1));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, CELLS));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 2 * WIDTH + 36));

    write_color_mode(1'b1);
    pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_PLOT, 2, 3, 0, 5, 8'h4A, 0));
    pending_items.push_back(make_item(OP_PLOT, 3, 3, 0, 5, 8'h4B, 0));
    pending_items.push_back(make_item(OP_SPAN, -1, 4, 3, 5, 8'h4C, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 4 * WIDTH));
    pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 3 * WIDTH + 3));

    for (int phase = 0; phase < 4; phase++) begin
      write_color_mode(phase[0]);
      repeat (RANDOM_PER_PHASE) pending_items.push_back(random_item());
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
